// ----- sv/jrfe_pkg.sv -----
// Package with shared types, codes and character constants of the JSON-RPC field extractor.
`timescale 1ns / 1ps
`default_nettype none
package jrfe_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 255;

  // Parser states.
  localparam logic [3:0] ST_INIT        = 4'd0;
  localparam logic [3:0] ST_OBJECT      = 4'd1;
  localparam logic [3:0] ST_KEY         = 4'd2;
  localparam logic [3:0] ST_AFTER_KEY   = 4'd3;
  localparam logic [3:0] ST_DISPATCH    = 4'd4;
  localparam logic [3:0] ST_STRING      = 4'd5;
  localparam logic [3:0] ST_PRIM        = 4'd6;
  localparam logic [3:0] ST_NESTED      = 4'd7;
  localparam logic [3:0] ST_SKIP_STRING = 4'd8;
  localparam logic [3:0] ST_SKIP_PRIM   = 4'd9;
  localparam logic [3:0] ST_SKIP_NESTED = 4'd10;
  localparam logic [3:0] ST_AFTER_VALUE = 4'd11;
  localparam logic [3:0] ST_DONE        = 4'd12;
  localparam logic [3:0] ST_FAILED      = 4'd13;

  // Field kinds.
  localparam logic [2:0] FK_METHOD  = 3'd0;
  localparam logic [2:0] FK_ID      = 3'd1;
  localparam logic [2:0] FK_PARAMS  = 3'd2;
  localparam logic [2:0] FK_JSONRPC = 3'd3;
  localparam logic [2:0] FK_UNKNOWN = 3'd4;

  // Value kinds.
  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_PRIM   = 2'd1;
  localparam logic [1:0] KIND_NESTED = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_OPEN    = 4'd1;
  localparam logic [3:0] ERR_BAD_OBJ    = 4'd2;
  localparam logic [3:0] ERR_NO_COLON   = 4'd3;
  localparam logic [3:0] ERR_NO_SEP     = 4'd4;
  localparam logic [3:0] ERR_EMPTY      = 4'd5;
  localparam logic [3:0] ERR_INCOMPLETE = 4'd6;
  localparam logic [3:0] ERR_FAILED     = 4'd7;
  localparam logic [3:0] ERR_DEPTH      = 4'd8;

  // Request opcodes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Characters.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int unsigned NUM_KEYS = 4;
  localparam logic [3:0]  KEY_POS_MAX = 4'd15;

  // Key names, left aligned, one byte per character.
  localparam logic [63:0] KEY_TXT [NUM_KEYS] = '{
    {"method", 16'h0}, {"id", 48'h0}, {"params", 16'h0}, {"jsonrpc", 8'h0}
  };
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd6, 4'd2, 4'd6, 4'd7};

  // Parser control state apart from the bracket depth.
  typedef struct packed {
    logic [3:0] parse_state;
    logic       esc;
    logic       in_str;
    logic [2:0] fk;
    logic [3:0] key_pos;
    logic [3:0] key_cand;
  } ctl_t;

  typedef struct packed {
    logic       object_begin;
    logic       value_valid;
    logic [7:0] value_byte;
    logic [1:0] field_tag;
    logic [1:0] value_kind;
    logic       value_end;
    logic       object_complete;
    logic       error_flag;
    logic [3:0] error_code;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage
`default_nettype wire

// ----- sv/jrfe_key_match.sv -----
// Key matcher: narrows the candidate key set by one key byte and classifies a finished key.
`timescale 1ns / 1ps
`default_nettype none
module jrfe_key_match (
  input  wire logic [7:0] c,
  input  wire logic [3:0] key_pos,
  input  wire logic [3:0] key_cand,
  output logic      [3:0] key_pos_nxt,
  output logic      [3:0] key_cand_nxt,
  output logic      [2:0] key_class
);

  always_comb begin
    key_cand_nxt = key_cand;
    for (int k = 0; k < jrfe_pkg::NUM_KEYS; k++) begin
      if (key_pos >= jrfe_pkg::KEY_LEN[k]) begin
        key_cand_nxt[k] = 1'b0;
      end else if (jrfe_pkg::KEY_TXT[k][63 - 8 * int'(key_pos[2:0]) -: 8] != c) begin
        key_cand_nxt[k] = 1'b0;
      end
    end
    key_pos_nxt = (key_pos < jrfe_pkg::KEY_POS_MAX) ? key_pos + 4'd1 : key_pos;
  end

  // The first surviving candidate whose length equals the bytes seen wins.
  always_comb begin
    key_class = jrfe_pkg::FK_UNKNOWN;
    for (int k = jrfe_pkg::NUM_KEYS - 1; k >= 0; k--) begin
      if (key_cand[k] && key_pos == jrfe_pkg::KEY_LEN[k]) begin
        key_class = 3'(k);
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/jrfe_step.sv -----
// Parser step: next parser state and the result for one request.
`timescale 1ns / 1ps
`default_nettype none
module jrfe_step #(
  parameter int unsigned MAX_DEPTH = jrfe_pkg::MAX_DEPTH_DEF,
  parameter int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic               op,
  input  wire logic [7:0]         c,
  input  wire jrfe_pkg::ctl_t     ctl,
  input  wire logic [DEPTH_W-1:0] depth,
  output jrfe_pkg::ctl_t          ctl_nxt,
  output logic      [DEPTH_W-1:0] depth_nxt,
  output jrfe_pkg::res_t          res
);

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

  logic [3:0] kp_nxt;
  logic [3:0] kc_nxt;
  logic [2:0] key_class;
  logic       ws;
  logic       open_br;
  logic       close_br;
  logic       tracked;
  logic       nest_end;
  logic [DEPTH_W-1:0] depth_dec;

  jrfe_key_match u_key (
    .c           (c),
    .key_pos     (ctl.key_pos),
    .key_cand    (ctl.key_cand),
    .key_pos_nxt (kp_nxt),
    .key_cand_nxt(kc_nxt),
    .key_class   (key_class)
  );

  assign ws        = jrfe_pkg::is_ws(c);
  assign open_br   = (c == jrfe_pkg::CH_LBRACE) || (c == jrfe_pkg::CH_LBRACK);
  assign close_br  = (c == jrfe_pkg::CH_RBRACE) || (c == jrfe_pkg::CH_RBRACK);
  assign depth_dec = (depth != '0) ? depth - DEPTH_ONE : depth;

  always_comb begin
    ctl_nxt   = ctl;
    depth_nxt = depth;
    res       = '0;
    tracked   = 1'b0;
    nest_end  = 1'b0;
    if (op == jrfe_pkg::OP_END) begin
      unique case (ctl.parse_state)
        jrfe_pkg::ST_DONE: begin
        end
        jrfe_pkg::ST_FAILED: begin
          res.error_flag = 1'b1;
          res.error_code = jrfe_pkg::ERR_FAILED;
        end
        jrfe_pkg::ST_INIT: begin
          ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
          res.error_flag      = 1'b1;
          res.error_code      = jrfe_pkg::ERR_EMPTY;
        end
        jrfe_pkg::ST_PRIM: begin
          res.field_tag       = ctl.fk[1:0];
          res.value_kind      = jrfe_pkg::KIND_PRIM;
          res.value_end       = 1'b1;
          ctl_nxt.fk          = jrfe_pkg::FK_UNKNOWN;
          ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
          res.error_flag      = 1'b1;
          res.error_code      = jrfe_pkg::ERR_INCOMPLETE;
        end
        default: begin
          ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
          res.error_flag      = 1'b1;
          res.error_code      = jrfe_pkg::ERR_INCOMPLETE;
        end
      endcase
    end else begin
      unique case (ctl.parse_state)
        jrfe_pkg::ST_INIT: begin
          if (!ws) begin
            if (c == jrfe_pkg::CH_LBRACE) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_OBJECT;
              res.object_begin    = 1'b1;
            end else begin
              ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
              res.error_flag      = 1'b1;
              res.error_code      = jrfe_pkg::ERR_NO_OPEN;
            end
          end
        end
        jrfe_pkg::ST_OBJECT: begin
          if (!ws && c != jrfe_pkg::CH_COMMA) begin
            if (c == jrfe_pkg::CH_RBRACE) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_DONE;
              res.object_complete = 1'b1;
            end else if (c == jrfe_pkg::CH_QUOTE) begin
              ctl_nxt.esc         = 1'b0;
              ctl_nxt.key_pos     = '0;
              ctl_nxt.key_cand    = '1;
              ctl_nxt.parse_state = jrfe_pkg::ST_KEY;
            end else begin
              ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
              res.error_flag      = 1'b1;
              res.error_code      = jrfe_pkg::ERR_BAD_OBJ;
            end
          end
        end
        jrfe_pkg::ST_KEY: begin
          if (ctl.esc) begin
            ctl_nxt.esc      = 1'b0;
            ctl_nxt.key_pos  = kp_nxt;
            ctl_nxt.key_cand = kc_nxt;
          end else if (c == jrfe_pkg::CH_BSLASH) begin
            ctl_nxt.esc = 1'b1;
          end else if (c == jrfe_pkg::CH_QUOTE) begin
            ctl_nxt.fk          = key_class;
            ctl_nxt.parse_state = jrfe_pkg::ST_AFTER_KEY;
          end else begin
            ctl_nxt.key_pos  = kp_nxt;
            ctl_nxt.key_cand = kc_nxt;
          end
        end
        jrfe_pkg::ST_AFTER_KEY: begin
          if (!ws) begin
            if (c == jrfe_pkg::CH_COLON) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_DISPATCH;
            end else begin
              ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
              res.error_flag      = 1'b1;
              res.error_code      = jrfe_pkg::ERR_NO_COLON;
            end
          end
        end
        jrfe_pkg::ST_DISPATCH: begin
          if (!ws) begin
            ctl_nxt.esc = 1'b0;
            if (c == jrfe_pkg::CH_QUOTE) begin
              ctl_nxt.parse_state = (ctl.fk == jrfe_pkg::FK_METHOD || ctl.fk == jrfe_pkg::FK_ID)
                                    ? jrfe_pkg::ST_STRING : jrfe_pkg::ST_SKIP_STRING;
            end else if (open_br) begin
              depth_nxt      = DEPTH_ONE;
              ctl_nxt.in_str = 1'b0;
              if (ctl.fk == jrfe_pkg::FK_PARAMS || ctl.fk == jrfe_pkg::FK_ID) begin
                ctl_nxt.parse_state = jrfe_pkg::ST_NESTED;
                res.value_valid     = 1'b1;
                res.value_byte      = c;
                res.field_tag       = ctl.fk[1:0];
                res.value_kind      = jrfe_pkg::KIND_NESTED;
              end else begin
                ctl_nxt.parse_state = jrfe_pkg::ST_SKIP_NESTED;
              end
            end else if (ctl.fk == jrfe_pkg::FK_ID) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_PRIM;
              res.value_valid     = 1'b1;
              res.value_byte      = c;
              res.field_tag       = ctl.fk[1:0];
              res.value_kind      = jrfe_pkg::KIND_PRIM;
            end else begin
              ctl_nxt.parse_state = jrfe_pkg::ST_SKIP_PRIM;
            end
          end
        end
        jrfe_pkg::ST_STRING, jrfe_pkg::ST_SKIP_STRING: begin
          tracked = (ctl.parse_state == jrfe_pkg::ST_STRING);
          res.field_tag  = tracked ? ctl.fk[1:0] : 2'd0;
          if (ctl.esc) begin
            ctl_nxt.esc     = 1'b0;
            res.value_valid = tracked;
          end else if (c == jrfe_pkg::CH_BSLASH) begin
            ctl_nxt.esc   = 1'b1;
            res.field_tag = 2'd0;
          end else if (c == jrfe_pkg::CH_QUOTE) begin
            res.value_end       = tracked;
            ctl_nxt.fk          = jrfe_pkg::FK_UNKNOWN;
            ctl_nxt.parse_state = jrfe_pkg::ST_AFTER_VALUE;
          end else begin
            res.value_valid = tracked;
          end
          res.value_byte = res.value_valid ? c : 8'd0;
          res.value_kind = jrfe_pkg::KIND_STRING;
        end
        jrfe_pkg::ST_PRIM, jrfe_pkg::ST_SKIP_PRIM: begin
          tracked = (ctl.parse_state == jrfe_pkg::ST_PRIM);
          if (c == jrfe_pkg::CH_COMMA || c == jrfe_pkg::CH_RBRACE || ws) begin
            res.value_end = tracked;
            ctl_nxt.fk    = jrfe_pkg::FK_UNKNOWN;
            if (c == jrfe_pkg::CH_COMMA) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_OBJECT;
            end else if (c == jrfe_pkg::CH_RBRACE) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_DONE;
              res.object_complete = 1'b1;
            end else begin
              ctl_nxt.parse_state = jrfe_pkg::ST_AFTER_VALUE;
            end
          end else begin
            res.value_valid = tracked;
            res.value_byte  = tracked ? c : 8'd0;
          end
          res.field_tag  = tracked ? ctl.fk[1:0] : 2'd0;
          res.value_kind = tracked ? jrfe_pkg::KIND_PRIM : jrfe_pkg::KIND_STRING;
        end
        jrfe_pkg::ST_NESTED, jrfe_pkg::ST_SKIP_NESTED: begin
          tracked = (ctl.parse_state == jrfe_pkg::ST_NESTED);
          if (ctl.esc) begin
            ctl_nxt.esc = 1'b0;
          end else if (ctl.in_str) begin
            if (c == jrfe_pkg::CH_BSLASH) begin
              ctl_nxt.esc = 1'b1;
            end else if (c == jrfe_pkg::CH_QUOTE) begin
              ctl_nxt.in_str = 1'b0;
            end
          end else if (c == jrfe_pkg::CH_QUOTE) begin
            ctl_nxt.in_str = 1'b1;
          end else if (open_br) begin
            if (depth >= DEPTH_MAX) begin
              // Overflow: nothing is streamed for this byte.
              tracked             = 1'b0;
              ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
              res.error_flag      = 1'b1;
              res.error_code      = jrfe_pkg::ERR_DEPTH;
            end else begin
              depth_nxt = depth + DEPTH_ONE;
            end
          end else if (close_br) begin
            depth_nxt = depth_dec;
            if (depth_dec == '0) begin
              nest_end            = 1'b1;
              ctl_nxt.parse_state = jrfe_pkg::ST_AFTER_VALUE;
            end
          end
          if (tracked) begin
            res.value_valid = 1'b1;
            res.value_byte  = c;
            res.field_tag   = ctl.fk[1:0];
            res.value_kind  = jrfe_pkg::KIND_NESTED;
            res.value_end   = nest_end;
          end
          if (nest_end) begin
            ctl_nxt.fk = jrfe_pkg::FK_UNKNOWN;
          end
        end
        jrfe_pkg::ST_AFTER_VALUE: begin
          if (!ws) begin
            if (c == jrfe_pkg::CH_COMMA) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_OBJECT;
            end else if (c == jrfe_pkg::CH_RBRACE) begin
              ctl_nxt.parse_state = jrfe_pkg::ST_DONE;
              res.object_complete = 1'b1;
            end else begin
              ctl_nxt.parse_state = jrfe_pkg::ST_FAILED;
              res.error_flag      = 1'b1;
              res.error_code      = jrfe_pkg::ERR_NO_SEP;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/jsonrpc_top_level_field_extractor.sv -----
// Top level of the JSON-RPC top-level field extractor: parser state and result register.
//
// One request (a body byte or an end-of-body marker) is taken per clock cycle and produces
// exactly one result, which appears in the output register on the cycle after acceptance.
// The parser state is updated in the same cycle as acceptance, so requests may follow each
// other with no gap; the input side stalls only while a result sits in the output register
// and the consumer holds out_ready low. Nesting deeper than MAX_DEPTH brackets inside a value
// reports a depth overflow error. After the object is complete or an error was reported,
// further bytes give all-zero results until reset.
`timescale 1ns / 1ps
`default_nettype none
module jsonrpc_top_level_field_extractor #(
  parameter int unsigned MAX_DEPTH = jrfe_pkg::MAX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_op,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_object_begin,
  output logic            out_value_valid,
  output logic      [7:0] out_value_byte,
  output logic      [1:0] out_field_tag,
  output logic      [1:0] out_value_kind,
  output logic            out_value_end,
  output logic            out_object_complete,
  output logic            out_error_flag,
  output logic      [3:0] out_error_code
);

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

  jrfe_pkg::ctl_t     ctl_r;
  jrfe_pkg::ctl_t     ctl_nxt;
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  jrfe_pkg::res_t     res_nxt;
  jrfe_pkg::res_t     res_r;
  logic               out_valid_r;
  logic               accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  jrfe_step #(
    .MAX_DEPTH(MAX_DEPTH),
    .DEPTH_W  (DEPTH_W)
  ) u_step (
    .op       (in_op),
    .c        (in_data_byte),
    .ctl      (ctl_r),
    .depth    (depth_r),
    .ctl_nxt  (ctl_nxt),
    .depth_nxt(depth_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.parse_state <= jrfe_pkg::ST_INIT;
      ctl_r.esc         <= 1'b0;
      ctl_r.in_str      <= 1'b0;
      ctl_r.fk          <= jrfe_pkg::FK_UNKNOWN;
      ctl_r.key_pos     <= '0;
      ctl_r.key_cand    <= '1;
      depth_r           <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (accept) begin
        ctl_r       <= ctl_nxt;
        depth_r     <= depth_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_object_begin    = res_r.object_begin;
  assign out_value_valid     = res_r.value_valid;
  assign out_value_byte      = res_r.value_byte;
  assign out_field_tag       = res_r.field_tag;
  assign out_value_kind      = res_r.value_kind;
  assign out_value_end       = res_r.value_end;
  assign out_object_complete = res_r.object_complete;
  assign out_error_flag      = res_r.error_flag;
  assign out_error_code      = res_r.error_code;

endmodule
`default_nettype wire
